// File: src/ffat_pkg.sv
`default_nettype none
package ffat_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam logic [15:0] LN2_Q16 = 16'd45426;
  localparam logic [16:0] ONE_Q16 = 17'h10000;
  // smallest |x| >> 16 whose exponent shift reaches 48
  localparam logic [21:0] EXP_LIMIT = 22'd2180448;

  typedef enum logic [1:0] {
    FOG_OFF    = 2'd0,
    FOG_LINEAR = 2'd1,
    FOG_EXP    = 2'd2
  } fog_mode_e;

  typedef enum logic [2:0] {
    REG_FOG_MODE      = 3'd0,
    REG_ALPHA_TEST_ON = 3'd1,
    REG_FOG_END       = 3'd2,
    REG_FOG_DENSITY   = 3'd3,
    REG_FOG_RED       = 3'd4,
    REG_FOG_GREEN     = 3'd5,
    REG_FOG_BLUE      = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } color_t;

  typedef struct packed {
    color_t      color;
    logic [31:0] w;
  } frag_t;

  typedef struct packed {
    fog_mode_e          mode;
    logic [31:0]        fog_end;
    logic signed [23:0] density;
  } fog_cfg_t;

  typedef struct packed {
    color_t      color;
    logic        pos;
    logic        big;
    logic [5:0]  n;
    logic [21:0] t;
  } exp_side_t;

endpackage
`default_nettype wire

// File: src/ffat_front.sv
`default_nettype none
module ffat_front import ffat_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire frag_t in_frag,
  input  wire logic  alpha_test_on,
  input  wire logic  pop,
  output logic       q_valid,
  output frag_t      q_frag
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  frag_t          mem [QDEPTH];
  logic [PW-1:0]  wp;
  logic [PW-1:0]  rp;
  logic [CW-1:0]  count;
  logic           push;
  logic           take;
  logic           discard;

  // alpha test: below half is dropped here
  assign discard  = alpha_test_on && !in_frag.color.alpha[7];
  assign in_ready = count != CW'(QDEPTH);
  assign push     = in_valid && in_ready && !discard;
  assign q_valid  = count != '0;
  assign take     = pop && q_valid;
  assign q_frag   = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_frag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(QDEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (take) begin
        rp <= (rp == PW'(QDEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/ffat_recip.sv
`default_nettype none
module ffat_recip import ffat_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   en,
  input  wire logic   in_valid,
  input  wire frag_t  in_frag,
  output logic        out_valid,
  output color_t      out_color,
  output logic [31:0] depth
);

  // one quotient bit of 2^32 / w per stage
  localparam int NS = 33;

  logic        v   [NS];
  color_t      col [NS];
  logic [32:0] q   [NS];
  logic [31:0] rem [NS-1];
  logic [31:0] wr  [NS-1];

  for (genvar i = 0; i < NS; i++) begin : g_st
    logic [31:0] rem_in;
    logic [31:0] w_in;
    logic [32:0] q_in;
    logic        v_in;
    color_t      c_in;
    logic [32:0] sh;
    logic        take;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign w_in   = in_frag.w;
      assign q_in   = '0;
      assign v_in   = in_valid;
      assign c_in   = in_frag.color;
    end else begin : g_next
      assign rem_in = rem[i-1];
      assign w_in   = wr[i-1];
      assign q_in   = q[i-1];
      assign v_in   = v[i-1];
      assign c_in   = col[i-1];
    end

    assign sh   = {rem_in, 1'(i == 0)};
    assign take = sh >= {1'b0, w_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q[i]   <= {q_in[31:0], take};
        col[i] <= c_in;
      end
    end

    if (i < NS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i] <= take ? 32'(sh - {1'b0, w_in}) : sh[31:0];
          wr[i]  <= w_in;
        end
      end
    end
  end

  // zero w or a quotient past 32 bits saturates
  assign depth     = q[NS-1][32] ? '1 : q[NS-1][31:0];
  assign out_valid = v[NS-1];
  assign out_color = col[NS-1];

endmodule
`default_nettype wire

// File: src/ffat_fog.sv
`default_nettype none
module ffat_fog import ffat_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     en,
  input  wire logic     in_valid,
  input  wire color_t   in_color,
  input  wire logic [31:0] depth,
  input  wire fog_cfg_t cfg,
  output logic          out_valid,
  output color_t        out_color,
  output logic [16:0]   fog_f
);

  localparam int NB   = 6;
  localparam int HS   = 8;
  localparam int LD   = 16;
  localparam int S_N0 = 2;
  localparam int S_H0 = S_N0 + NB;
  localparam int S_F  = S_H0 + 3 * HS;
  localparam int NS   = S_F + 1;

  logic               v    [NS];
  color_t             col0;
  logic signed [56:0] x0;
  exp_side_t          sd   [1:S_F-1];
  logic [47:0]        hprod [HS];
  logic [31:0]        hx    [HS];
  logic [67:0]        hxm   [HS];
  logic [32:0]        hp    [HS];
  logic [31:0]        lrem [0:LD-1];
  logic [15:0]        lq   [1:LD];
  logic               lz   [0:LD];
  logic [15:0]        ldly [LD+1:S_F-1];

  for (genvar i = 0; i < NS; i++) begin : g_v
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= (i == 0) ? in_valid : v[(i == 0) ? 0 : i - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col0    <= in_color;
      x0      <= cfg.density * $signed({1'b0, depth});
      lz[0]   <= depth >= cfg.fog_end;
      lrem[0] <= cfg.fog_end - depth;
    end
  end

  // linear: (end - depth) << 16 / end, one bit per stage
  for (genvar i = 1; i <= LD; i++) begin : g_lin
    logic [32:0] sh;
    logic [15:0] q_in;
    logic        take;

    assign sh   = {lrem[i-1], 1'b0};
    assign take = sh >= {1'b0, cfg.fog_end};
    if (i == 1) begin : g_first
      assign q_in = '0;
    end else begin : g_next
      assign q_in = lq[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lq[i] <= {q_in[14:0], take};
        lz[i] <= lz[i-1];
      end
    end

    if (i < LD) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          lrem[i] <= take ? 32'(sh - {1'b0, cfg.fog_end}) : sh[31:0];
        end
      end
    end
  end

  for (genvar i = LD + 1; i <= S_F - 1; i++) begin : g_ldly
    always_ff @(posedge clk) begin
      if (en) begin
        if (i == LD + 1) begin
          ldly[i] <= lz[LD] ? 16'd0 : lq[LD];
        end else begin
          ldly[i] <= ldly[(i == LD + 1) ? i : i - 1];
        end
      end
    end
  end

  // exponential: sign, range and |x| >> 16
  logic [56:0] negx;
  logic [40:0] tfull;
  assign negx  = 57'(-x0);
  assign tfull = negx[56:16];

  always_ff @(posedge clk) begin
    if (en) begin
      sd[1].color <= col0;
      sd[1].pos   <= !x0[56];
      sd[1].big   <= tfull >= 41'(EXP_LIMIT);
      sd[1].n     <= '0;
      sd[1].t     <= negx[37:16];
    end
  end

  // n = t / ln2, one bit per stage, remainder left in t
  for (genvar i = 0; i < NB; i++) begin : g_ndiv
    localparam int IDX = S_N0 + i;
    localparam logic [21:0] DV = 22'(LN2_Q16) << (NB - 1 - i);
    logic      take;
    exp_side_t sd_next;
    assign take = sd[IDX-1].t >= DV;

    always_comb begin
      sd_next = sd[IDX-1];
      if (take) begin
        sd_next.t             = sd[IDX-1].t - DV;
        sd_next.n[NB - 1 - i] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[IDX] <= sd_next;
      end
    end
  end

  // horner steps for exp(-r), k from eight down to one
  for (genvar kk = 0; kk < HS; kk++) begin : g_horner
    localparam int B = S_H0 + 3 * kk;
    localparam int K = HS - kk;
    localparam logic [35:0] RECIP = 36'((64'd1 << 35) / K);
    logic [32:0] p_in;
    logic [31:0] q0;
    logic [31:0] rm;
    logic [31:0] qk;

    if (kk == 0) begin : g_first
      assign p_in = 33'h1_0000_0000;
    end else begin : g_next
      assign p_in = hp[kk-1];
    end

    assign q0 = 32'(hxm[kk] >> 35);
    assign rm = hx[kk] - 32'(q0 * 32'(K));
    assign qk = (rm >= 32'(K)) ? q0 + 1'b1 : q0;

    always_ff @(posedge clk) begin
      if (en) begin
        hprod[kk] <= 48'({32'd0, sd[B-1].t[15:0]} * {15'd0, p_in});
        sd[B]     <= sd[B-1];
        hx[kk]    <= hprod[kk][47:16];
        hxm[kk]   <= {36'd0, hprod[kk][47:16]} * {32'd0, RECIP};
        sd[B+1]   <= sd[B];
        hp[kk]    <= 33'h1_0000_0000 - {1'b0, qk};
        sd[B+2]   <= sd[B+1];
      end
    end
  end

  logic [32:0] pshift;
  logic [16:0] f_exp;
  logic [16:0] f_sel;

  assign pshift = hp[HS-1] >> (7'd16 + 7'(sd[S_F-1].n));

  always_comb begin
    if (sd[S_F-1].pos) begin
      f_exp = ONE_Q16;
    end else if (sd[S_F-1].big) begin
      f_exp = '0;
    end else begin
      f_exp = pshift[16:0];
    end
    unique case (cfg.mode)
      FOG_LINEAR: f_sel = {1'b0, ldly[S_F-1]};
      FOG_EXP:    f_sel = f_exp;
      default:    f_sel = ONE_Q16;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fog_f     <= f_sel;
      out_color <= sd[S_F-1].color;
    end
  end

  assign out_valid = v[S_F];

endmodule
`default_nettype wire

// File: src/ffat_mix.sv
`default_nettype none
module ffat_mix import ffat_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire color_t      in_color,
  input  wire logic [16:0] fog_f,
  input  wire logic [7:0]  fog_red,
  input  wire logic [7:0]  fog_green,
  input  wire logic [7:0]  fog_blue,
  output logic             out_valid,
  output color_t           out_color
);

  logic        mv;
  logic [24:0] pf [3];
  logic [24:0] pc [3];
  logic [7:0]  alpha_m;
  logic [16:0] inv_f;
  logic [7:0]  fogc [3];
  logic [7:0]  cin  [3];
  logic [7:0]  res  [3];

  assign inv_f   = ONE_Q16 - fog_f;
  assign fogc[0] = fog_red;
  assign fogc[1] = fog_green;
  assign fogc[2] = fog_blue;
  assign cin[0]  = in_color.red;
  assign cin[1]  = in_color.green;
  assign cin[2]  = in_color.blue;

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [25:0] sum;
    assign sum    = 26'(pf[c]) + 26'(pc[c]) + 26'd32768;
    assign res[c] = sum[23:16];
    always_ff @(posedge clk) begin
      if (en) begin
        pf[c] <= 25'(fogc[c]) * 25'(inv_f);
        pc[c] <= 25'(cin[c]) * 25'(fog_f);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mv        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mv        <= in_valid;
      out_valid <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alpha_m         <= in_color.alpha;
      out_color.red   <= res[0];
      out_color.green <= res[1];
      out_color.blue  <= res[2];
      out_color.alpha <= alpha_m;
    end
  end

endmodule
`default_nettype wire

// File: src/fragment_fog_alpha_test.sv
// throughput: one fragment per cycle while the output is not stalled,
// set by the fully pipelined divider and exp stages
// discarded fragments are accepted at the input and give no result
// rst is synchronous: empties the queue and pipeline and restores register defaults
`default_nettype none
module fragment_fog_alpha_test import ffat_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // in_red, in_green, in_blue, in_alpha, frag_w
  input  wire logic [63:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [31:0]      m_axis_tdata,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  fog_cfg_t    cfg;
  logic        alpha_test_on;
  logic [7:0]  fog_red;
  logic [7:0]  fog_green;
  logic [7:0]  fog_blue;
  logic        en;
  frag_t       in_frag;
  logic        q_valid;
  frag_t       q_frag;
  logic        rec_valid;
  color_t      rec_color;
  logic [31:0] depth;
  logic        fog_valid;
  color_t      fog_color;
  logic [16:0] fog_f;
  color_t      out_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode      <= FOG_OFF;
      alpha_test_on <= 1'b0;
      cfg.fog_end   <= 32'h0001_0000;
      cfg.density   <= '0;
      fog_red       <= '0;
      fog_green     <= '0;
      fog_blue      <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_FOG_MODE:      cfg.mode      <= fog_mode_e'(cfg_data[1:0]);
        REG_ALPHA_TEST_ON: alpha_test_on <= cfg_data[0];
        REG_FOG_END:       cfg.fog_end   <= cfg_data;
        REG_FOG_DENSITY:   cfg.density   <= $signed(cfg_data[23:0]);
        REG_FOG_RED:       fog_red       <= cfg_data[7:0];
        REG_FOG_GREEN:     fog_green     <= cfg_data[7:0];
        REG_FOG_BLUE:      fog_blue      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // whole back end moves together, held while a result waits
  assign en = !m_axis_tvalid || m_axis_tready;

  assign in_frag.color.red   = s_axis_tdata[7:0];
  assign in_frag.color.green = s_axis_tdata[15:8];
  assign in_frag.color.blue  = s_axis_tdata[23:16];
  assign in_frag.color.alpha = s_axis_tdata[31:24];
  assign in_frag.w           = s_axis_tdata[63:32];

  ffat_front #(.QDEPTH(QDEPTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_frag      (in_frag),
    .alpha_test_on(alpha_test_on),
    .pop          (en),
    .q_valid      (q_valid),
    .q_frag       (q_frag)
  );

  ffat_recip u_recip (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (q_valid),
    .in_frag  (q_frag),
    .out_valid(rec_valid),
    .out_color(rec_color),
    .depth    (depth)
  );

  ffat_fog u_fog (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (rec_valid),
    .in_color (rec_color),
    .depth    (depth),
    .cfg      (cfg),
    .out_valid(fog_valid),
    .out_color(fog_color),
    .fog_f    (fog_f)
  );

  ffat_mix u_mix (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (fog_valid),
    .in_color (fog_color),
    .fog_f    (fog_f),
    .fog_red  (fog_red),
    .fog_green(fog_green),
    .fog_blue (fog_blue),
    .out_valid(m_axis_tvalid),
    .out_color(out_color)
  );

  assign m_axis_tdata = {out_color.alpha, out_color.blue, out_color.green, out_color.red};

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk) disable iff (rst) !s_axis_tready |-> q_valid)
    else $error("input stalled with an empty queue");
  assert property (@(posedge clk) disable iff (rst) !en |=> fog_valid == $past(fog_valid))
    else $error("pipeline moved while output stalled");
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire

// File: tb/tb_fragment_fog_alpha_test.sv
`default_nettype none
module tb_fragment_fog_alpha_test;
  import ffat_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // in_red, in_green, in_blue, in_alpha, frag_w
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // out_red, out_green, out_blue, out_alpha
  logic [31:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  fragment_fog_alpha_test u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [1:0]         sh_mode;
  logic               sh_atest;
  logic [31:0]        sh_end;
  logic signed [23:0] sh_density;
  logic [7:0]         sh_fr, sh_fg, sh_fb;

  logic [63:0] frag_q[$];
  logic [31:0] color_q[$];
  int          mismatches = 0;
  bit          driving = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_phase = 0;

  function automatic logic [31:0] eye_depth(logic [31:0] w);
    logic [63:0] q;
    if (w == 0) return 32'hFFFF_FFFF;
    q = 64'h1_0000_0000 / w;
    if (q > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
    return q[31:0];
  endfunction

  function automatic logic [16:0] fog_factor(logic [31:0] w);
    logic [31:0] d;
    logic signed [63:0] x;
    logic [63:0] t, n, r, p;
    d = eye_depth(w);
    if (sh_mode == FOG_LINEAR) begin
      if (sh_end == 0 || d >= sh_end) return '0;
      return 17'(((64'(sh_end - d)) << 16) / sh_end);
    end
    if (sh_mode == FOG_EXP) begin
      x = 64'(sh_density) * $signed({32'd0, d});
      if (x >= 0) return ONE_Q16;
      t = 64'(-x) >> 16;
      n = t / 45426;
      r = t - n * 45426;
      if (n >= 48) return '0;
      p = 64'h1_0000_0000;
      for (int k = 8; k >= 1; k--) p = 64'h1_0000_0000 - (((r * p) >> 16) / k);
      return 17'(p >> (16 + n));
    end
    return ONE_Q16;
  endfunction

  function automatic logic [7:0] blend(logic [7:0] fc, logic [7:0] c, logic [16:0] f);
    logic [63:0] s;
    s = (64'(fc) * (65536 - f) + 64'(c) * f + 32768) >> 16;
    return s[7:0];
  endfunction

  function automatic void predict(logic [63:0] d);
    logic [7:0] r, g, b, a;
    logic [16:0] f;
    r = d[7:0]; g = d[15:8]; b = d[23:16]; a = d[31:24];
    if (sh_atest && a < 128) return;
    f = fog_factor(d[63:32]);
    color_q.push_back({a, blend(sh_fb, b, f), blend(sh_fg, g, f), blend(sh_fr, r, f)});
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) predict(s_axis_tdata);
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (driving && frag_q.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= frag_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      stall_phase <= (stall_phase + 1) % 97;
      m_axis_tready <= (stall_phase < 40) ? 1'b1 :
                       (stall_phase < 70) ? ($urandom_range(0, 3) != 0) :
                       ($urandom_range(0, 1) == 1);
      if (m_axis_tvalid && m_axis_tready) begin
        if (color_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          logic [31:0] e;
          e = color_q.pop_front();
          if (e != m_axis_tdata) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h actual %h", e, m_axis_tdata);
          end
        end
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      REG_FOG_MODE:      sh_mode = v[1:0];
      REG_ALPHA_TEST_ON: sh_atest = v[0];
      REG_FOG_END:       sh_end = v;
      REG_FOG_DENSITY:   sh_density = v[23:0];
      REG_FOG_RED:       sh_fr = v[7:0];
      REG_FOG_GREEN:     sh_fg = v[7:0];
      default:           sh_fb = v[7:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    driving = 1;
    while (frag_q.size() > 0 || s_axis_tvalid || color_q.size() > 0) @(posedge clk);
    driving = 0;
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_w();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return $urandom_range(1 << 12, 1 << 18);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    sh_mode = FOG_OFF; sh_atest = 0; sh_end = 65536; sh_density = 0;
    sh_fr = 0; sh_fg = 0; sh_fb = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // directed: field extremes, alpha threshold, w zero and one
    write_reg(REG_FOG_MODE, FOG_OFF);
    frag_q.push_back({32'd0, 32'd0});
    frag_q.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF});
    drain();
    write_reg(REG_ALPHA_TEST_ON, 1);
    write_reg(REG_FOG_RED, 255); write_reg(REG_FOG_GREEN, 128); write_reg(REG_FOG_BLUE, 7);
    write_reg(REG_FOG_MODE, FOG_LINEAR);
    frag_q.push_back({32'd65536, 8'd127, 24'h123456});
    frag_q.push_back({32'd65536, 8'd128, 24'h123456});
    frag_q.push_back({32'd0, 8'd255, 24'habcdef});
    frag_q.push_back({32'd1, 8'd200, 24'habcdef});
    frag_q.push_back({32'd131072, 8'd200, 24'hffffff});
    drain();
    write_reg(REG_FOG_END, 0);
    frag_q.push_back({32'd1000, 32'h80ff_00ff});
    drain();
    write_reg(REG_FOG_END, 32'hFFFF_FFFF);
    frag_q.push_back({32'd1, 32'h80ff_00ff});
    frag_q.push_back({32'hFFFF_FFFF, 32'h80ff_00ff});
    drain();
    write_reg(REG_FOG_MODE, FOG_EXP);
    write_reg(REG_FOG_DENSITY, 24'h800000);
    frag_q.push_back({32'd65536, 32'hff10_2030});
    frag_q.push_back({32'd0, 32'hff10_2030});
    drain();
    write_reg(REG_FOG_DENSITY, 24'h7FFFFF);
    frag_q.push_back({32'd65536, 32'hff10_2030});
    drain();
    write_reg(REG_FOG_MODE, 3);
    frag_q.push_back({32'd5, 32'hff10_2030});
    drain();
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= 3'd7; cfg_data <= 32'hFFFF_FFFF;
    @(posedge clk);
    cfg_we <= 1'b0;
    frag_q.push_back({32'd5, 32'hff10_2030});
    drain();
    // random phases
    for (int ph = 0; ph < 15; ph++) begin
      write_reg(REG_FOG_MODE, $urandom_range(0, 3));
      write_reg(REG_ALPHA_TEST_ON, $urandom_range(0, 1));
      write_reg(REG_FOG_END, ($urandom_range(0, 1)) ? $urandom : $urandom_range(1, 1 << 20));
      write_reg(REG_FOG_DENSITY, ($urandom_range(0, 3) != 0) ?
                -$urandom_range(1, 1 << 18) : $urandom);
      write_reg(REG_FOG_RED, $urandom);
      write_reg(REG_FOG_GREEN, $urandom);
      write_reg(REG_FOG_BLUE, $urandom);
      for (int i = 0; i < 100; i++) frag_q.push_back({rand_w(), 32'($urandom)});
      drain();
    end
    if (mismatches == 0 && color_q.size() == 0) begin
      $display("fragment_fog_alpha_test verification clean");
    end else begin
      $display("fragment_fog_alpha_test verification failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("fragment_fog_alpha_test verification failed");
    $finish;
  end
endmodule
`default_nettype wire
